/* design/ulci_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ulci_pkg
// Shared types, constants and reply text for the LED command interpreter.
// ----------------------------------------------------------------------------
package ulci_pkg;

  localparam int ULCI_LINE_BYTES = 10;
  localparam int ULCI_OUT_IDX_W  = 5;   // up to 22 bytes per request

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR_HI = 8'h0D; // top of the control whitespace range
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [7:0] MAG_SAT  = 8'hFF;
  localparam logic [7:0] LED_MAX  = 8'd7;
  localparam logic [7:0] LED_RST  = 8'hFF;

  // reply kinds
  localparam logic [1:0] KIND_BAD_CMD = 2'd0;
  localparam logic [1:0] KIND_BAD_NUM = 2'd1;
  localparam logic [1:0] KIND_LED_ON  = 2'd2;
  localparam logic [1:0] KIND_LED_OFF = 2'd3;

  localparam int LEN_BAD_CMD = 17;
  localparam int LEN_BAD_NUM = 20;
  localparam int LEN_LED_ON  = 10;
  localparam int LEN_LED_OFF = 11;
  localparam int LED_DIGIT_POS = 4;

  localparam logic [8*LEN_BAD_CMD-1:0] MSG_BAD_CMD = {"Invalid Command", CH_CR, CH_LF};
  localparam logic [8*LEN_BAD_NUM-1:0] MSG_BAD_NUM = {"Invalid LED number", CH_CR, CH_LF};
  localparam logic [8*LEN_LED_ON-1:0]  MSG_LED_ON  = {"LED 0 ON", CH_CR, CH_LF};
  localparam logic [8*LEN_LED_OFF-1:0] MSG_LED_OFF = {"LED 0 OFF", CH_CR, CH_LF};

  // parser phases
  localparam logic [2:0] PH_C0  = 3'd0;
  localparam logic [2:0] PH_C1  = 3'd1;
  localparam logic [2:0] PH_C2  = 3'd2;
  localparam logic [2:0] PH_WS  = 3'd3;
  localparam logic [2:0] PH_DIG = 3'd4;

  typedef struct packed {
    logic accept;   // input request taken this cycle
    logic proc;     // consume the character read from the line store
    logic fin;      // settle the reply and the LED port
    logic emit;     // load the next byte into the output register
  } ulci_cmd_t;

  typedef struct packed {
    logic in_is_cr;
    logic scan_end;
    logic proc_term;
    logic emit_last;
    logic out_free;
  } ulci_sts_t;

  function automatic logic [ULCI_OUT_IDX_W-1:0] msg_len(logic [1:0] kind);
    logic [ULCI_OUT_IDX_W-1:0] n;
    n = '0;
    case (kind)
      KIND_BAD_CMD: n = ULCI_OUT_IDX_W'(LEN_BAD_CMD);
      KIND_BAD_NUM: n = ULCI_OUT_IDX_W'(LEN_BAD_NUM);
      KIND_LED_ON:  n = ULCI_OUT_IDX_W'(LEN_LED_ON);
      default:      n = ULCI_OUT_IDX_W'(LEN_LED_OFF);
    endcase
    return n;
  endfunction

  function automatic logic [7:0] msg_byte(logic [1:0] kind,
                                          logic [ULCI_OUT_IDX_W-1:0] idx,
                                          logic [2:0] num);
    logic [7:0] b;
    int i;
    i = int'(idx);
    b = CH_NUL;
    case (kind)
      KIND_BAD_CMD: if (i < LEN_BAD_CMD) b = MSG_BAD_CMD[8*(LEN_BAD_CMD-1-i) +: 8];
      KIND_BAD_NUM: if (i < LEN_BAD_NUM) b = MSG_BAD_NUM[8*(LEN_BAD_NUM-1-i) +: 8];
      KIND_LED_ON: begin
        if (i == LED_DIGIT_POS) b = CH_ZERO + {5'b0, num};
        else if (i < LEN_LED_ON) b = MSG_LED_ON[8*(LEN_LED_ON-1-i) +: 8];
      end
      default: begin
        if (i == LED_DIGIT_POS) b = CH_ZERO + {5'b0, num};
        else if (i < LEN_LED_OFF) b = MSG_LED_OFF[8*(LEN_LED_OFF-1-i) +: 8];
      end
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

/* design/ulci_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ulci_ctrl
// Sequencer: accept a byte, on a carriage return scan the stored line and settle, send the reply.
// ----------------------------------------------------------------------------
module ulci_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire ulci_pkg::ulci_sts_t sts,
  output ulci_pkg::ulci_cmd_t    cmd
);
  import ulci_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_PROC = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.in_is_cr ? S_SCAN : S_EMIT;
        end
      end
      S_SCAN: begin
        // read of the store is in flight unless the line is exhausted
        state_nxt = sts.scan_end ? S_FIN : S_PROC;
      end
      S_PROC: begin
        cmd.proc  = 1'b1;
        state_nxt = sts.proc_term ? S_FIN : S_SCAN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

/* design/ulci_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ulci_dp
// Line store, number parser, LED port and output register.
// ----------------------------------------------------------------------------
module ulci_dp #(
  parameter int LINE_BYTES = ulci_pkg::ULCI_LINE_BYTES
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [7:0]          in_tdata,
  input  wire ulci_pkg::ulci_cmd_t cmd,
  output ulci_pkg::ulci_sts_t      sts,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [15:0]              out_tdata,
  output logic                     out_tlast
);
  import ulci_pkg::*;

  localparam int STORE_DEPTH = LINE_BYTES - 1;
  localparam int IDX_W       = $clog2(STORE_DEPTH);

  logic [7:0]       mem [STORE_DEPTH];
  logic [7:0]       rd_data_r;
  logic [IDX_W-1:0] len_r, len_nxt;
  logic [IDX_W-1:0] pos_r;
  logic [2:0]       phase_r;
  logic             neg_r, on_r;
  logic [7:0]       mag_r;
  logic [7:0]       led_r;
  logic             is_cr_r;
  logic [7:0]       echo_r;
  logic [1:0]       kind_r;
  logic [2:0]       num_r;
  logic [ULCI_OUT_IDX_W-1:0] eidx_r;

  logic [7:0]       ob_r, ol_r;
  logic             olast_r, ovalid_r;

  // character classes of the byte read back
  logic [7:0]  d;
  logic        d_digit, d_ws, d_sign;
  logic [11:0] mag_sum;
  logic [7:0]  mag_nxt;
  logic        term;

  assign d       = rd_data_r;
  assign d_digit = (d >= CH_ZERO) && (d <= CH_NINE);
  assign d_ws    = (d == CH_SPACE) || ((d >= CH_TAB) && (d <= CH_CR_HI));
  assign d_sign  = (d == CH_PLUS) || (d == CH_MINUS);
  assign mag_sum = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0} + {8'b0, d[3:0]};
  assign mag_nxt = (mag_sum > {4'b0, MAG_SAT}) ? MAG_SAT : mag_sum[7:0];

  always_comb begin
    term = 1'b0;
    case (phase_r)
      PH_C0:   term = (d != CH_O);
      PH_C1:   term = (d != CH_N) && (d != CH_F);
      PH_C2:   term = (d != CH_F);
      PH_WS:   term = !d_ws && !d_sign && !d_digit;
      default: term = !d_digit;
    endcase
    if (d == CH_NUL) term = 1'b1;
  end

  // reply selection at the end of the scan
  logic       cmd_ok, num_ok;
  logic [7:0] led_mask;
  assign cmd_ok   = (phase_r == PH_WS) || (phase_r == PH_DIG);
  assign num_ok   = !(neg_r && (mag_r != 8'd0)) && (mag_r <= LED_MAX);
  assign led_mask = 8'd1 << mag_r[2:0];

  // output sequencing
  logic [ULCI_OUT_IDX_W-1:0] total;
  logic [7:0]                next_byte;
  assign total = is_cr_r ? (ULCI_OUT_IDX_W'(2) + msg_len(kind_r)) : ULCI_OUT_IDX_W'(1);

  always_comb begin
    if (eidx_r == '0)                         next_byte = echo_r;
    else if (eidx_r == ULCI_OUT_IDX_W'(1))    next_byte = CH_LF;
    else next_byte = msg_byte(kind_r, eidx_r - ULCI_OUT_IDX_W'(2), num_r);
  end

  assign len_nxt = (len_r == IDX_W'(STORE_DEPTH - 1)) ? '0 : len_r + 1'b1;

  assign sts.in_is_cr  = (in_tdata == CH_CR);
  assign sts.scan_end  = (pos_r == len_r);
  assign sts.proc_term = term;
  assign sts.emit_last = (eidx_r == total - 1'b1);
  assign sts.out_free  = !ovalid_r || out_tready;

  // line store
  always_ff @(posedge clk) begin
    if (cmd.accept && !sts.in_is_cr) mem[len_r] <= in_tdata;
    rd_data_r <= mem[pos_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      led_r    <= LED_RST;
      ovalid_r <= 1'b0;
    end else begin
      if (cmd.accept && !sts.in_is_cr) len_r <= len_nxt;
      if (cmd.fin) begin
        len_r <= '0;
        if (cmd_ok && num_ok) led_r <= on_r ? (led_r & ~led_mask) : (led_r | led_mask);
      end
      if (cmd.emit)      ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      echo_r  <= in_tdata;
      is_cr_r <= sts.in_is_cr;
      eidx_r  <= '0;
      pos_r   <= '0;
      phase_r <= PH_C0;
      neg_r   <= 1'b0;
      on_r    <= 1'b0;
      mag_r   <= 8'd0;
    end
    if (cmd.proc) begin
      pos_r <= pos_r + 1'b1;
      case (phase_r)
        PH_C0: if (d == CH_O) phase_r <= PH_C1;
        PH_C1: begin
          if (d == CH_N) begin
            on_r    <= 1'b1;
            phase_r <= PH_WS;
          end else if (d == CH_F) begin
            phase_r <= PH_C2;
          end
        end
        PH_C2: if (d == CH_F) phase_r <= PH_WS;
        PH_WS: begin
          if (d_sign) begin
            neg_r   <= (d == CH_MINUS);
            phase_r <= PH_DIG;
          end else if (d_digit) begin
            mag_r   <= {4'b0, d[3:0]};
            phase_r <= PH_DIG;
          end
        end
        default: if (d_digit) mag_r <= mag_nxt;
      endcase
    end
    if (cmd.fin) begin
      num_r <= mag_r[2:0];
      if (!cmd_ok)      kind_r <= KIND_BAD_CMD;
      else if (!num_ok) kind_r <= KIND_BAD_NUM;
      else              kind_r <= on_r ? KIND_LED_ON : KIND_LED_OFF;
    end
    if (cmd.emit) begin
      ob_r    <= next_byte;
      olast_r <= sts.emit_last;
      ol_r    <= led_r;
      eidx_r  <= eidx_r + 1'b1;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {ol_r, ob_r};
  assign out_tlast  = olast_r;

endmodule
`default_nettype wire

/* design/uart_led_command_interpreter_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uart_led_command_interpreter_top
// Interprets ON<n> / OFF<n> command lines and drives an active-low LED port.
//
// Input channel: one received byte per request. Output channel: the echo,
// then for a carriage return a line feed and the reply text; tlast marks
// the final byte for that input, and every output byte carries the LED
// port levels as they stand after the input.
// A carriage return scans the stored line character by character (store
// read, then parse), sees the end of the line, settles the reply and the
// LED port, then sends one byte a cycle while the receiver takes them.
// A new byte is taken once the previous reply has been loaded, even if its
// last byte still waits in the output register.
// Reset clears the line count and sets all LEDs off (port 0xff).
// When the receiver stalls, the output byte holds and the sequencer waits.
// ----------------------------------------------------------------------------
module uart_led_command_interpreter_top #(
  parameter int LINE_BYTES = ulci_pkg::ULCI_LINE_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,   // [7:0] tx_byte, [15:8] led_levels
  output logic             out_tlast
);
  import ulci_pkg::*;

  ulci_cmd_t cmd;
  ulci_sts_t sts;

  ulci_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ulci_dp #(
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
